// ===== rtl/dmtq_pkg.sv =====
`timescale 1ns / 1ps

package dmtq_pkg;

	// Queue geometry
	localparam int DEPTH_DEF   = 16;
	localparam int MAX_RELEASE = 16;
	localparam int REL_W       = $clog2(MAX_RELEASE + 1);

	// Field widths
	localparam int TIME_W   = 32;
	localparam int HANDLE_W = 16;
	localparam int DEST_W   = 4;
	localparam int DELAY_W  = 16;

	// Input actions
	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_TICK    = 1'b1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_RELEASED = 2'd2
	} kind_t;

	// Input word
	typedef struct packed {
		logic                action;
		logic [HANDLE_W-1:0] msg_handle;
		logic [DEST_W-1:0]   dest_id;
		logic [DELAY_W-1:0]  delay;
	} req_t;

	// Result word
	typedef struct packed {
		kind_t               kind;
		logic [HANDLE_W-1:0] out_handle;
		logic [DEST_W-1:0]   out_dest;
		logic                last;
	} rsp_t;

	// One queue slot
	typedef struct packed {
		logic [TIME_W-1:0]   expiry;
		logic [HANDLE_W-1:0] handle;
		logic [DEST_W-1:0]   dest;
	} slot_t;

	// True when expiry a lies strictly after reference b, wrap-safe
	function automatic logic later_than(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[TIME_W-1];
	endfunction

endpackage

// ===== rtl/delayed_message_timer_queue_core.sv =====
// Enqueue: the new entry walks in from the tail, shifting each queued entry with a later
// expiry back one slot, and ends with an accepted result; a full queue rejects with a result.
// Tick: advances time and releases due entries from the head (at most 16), one result per
// released entry, the last one marked last; a tick with nothing due ends with no result.
// Busy is high for the whole walk; results are one-cycle strobes, the receiver cannot stall.
// Reset (arst_n low, asynchronous) clears time, count and head; slot memory needs no clearing.
`timescale 1ns / 1ps

module delayed_message_timer_queue_core import dmtq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic rsp_valid,
	output rsp_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_REL_RD,
		ST_REL_CMP
	} state_t;

	state_t             state_q;
	logic [TIME_W-1:0]  now_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      k_q;
	logic [REL_W-1:0]   n_q;
	slot_t              new_q;
	slot_t              pend_q;
	logic               pend_valid_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	slot_t              mem_q [DEPTH];
	slot_t              rdata_q;

	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      slot_addr;
	logic               wr_en;
	slot_t              wr_data;
	logic               ins_later;
	logic               rel_due;

	// Add two slot offsets modulo DEPTH
	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign busy      = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Address the walk: read one slot toward the head, write the slot behind it
	always_comb begin
		slot_addr = wrap_add(head_q, k_q);
		rd_addr   = (state_q == ST_REL_RD) ? head_q : wrap_add(head_q, k_q - AW'(1));
		ins_later = later_than(rdata_q.expiry, new_q.expiry);
		rel_due   = (count_q != '0) && (n_q < REL_W'(MAX_RELEASE))
			&& !later_than(rdata_q.expiry, now_q);
		wr_en     = ((state_q == ST_INS_RD) && (k_q == '0)) || (state_q == ST_INS_CMP);
		wr_data   = ((state_q == ST_INS_CMP) && ins_later) ? rdata_q : new_q;
	end

	// Slot memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[slot_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	// Sequence enqueue walks and release bursts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			count_q      <= '0;
			head_q       <= '0;
			k_q          <= '0;
			n_q          <= '0;
			new_q        <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.action == ACT_TICK) begin
							now_q        <= now_q + TIME_W'(1);
							n_q          <= '0;
							pend_valid_q <= 1'b0;
							state_q      <= ST_REL_RD;
						end else if (count_q == CW'(DEPTH)) begin
							rsp_valid_q      <= 1'b1;
							rsp_q.kind       <= KIND_REJECTED;
							rsp_q.out_handle <= req.msg_handle;
							rsp_q.out_dest   <= req.dest_id;
							rsp_q.last       <= 1'b1;
						end else begin
							new_q.expiry <= now_q + TIME_W'(req.delay);
							new_q.handle <= req.msg_handle;
							new_q.dest   <= req.dest_id;
							k_q          <= count_q[AW-1:0];
							state_q      <= ST_INS_RD;
						end
					end
				end
				ST_INS_RD: begin
					if (k_q == '0) begin
						rsp_valid_q      <= 1'b1;
						rsp_q.kind       <= KIND_ACCEPTED;
						rsp_q.out_handle <= new_q.handle;
						rsp_q.out_dest   <= new_q.dest;
						rsp_q.last       <= 1'b1;
						count_q          <= count_q + CW'(1);
						state_q          <= ST_IDLE;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					// Shift a later entry back one slot, or drop the new word in place
					if (ins_later) begin
						k_q     <= k_q - AW'(1);
						state_q <= ST_INS_RD;
					end else begin
						rsp_valid_q      <= 1'b1;
						rsp_q.kind       <= KIND_ACCEPTED;
						rsp_q.out_handle <= new_q.handle;
						rsp_q.out_dest   <= new_q.dest;
						rsp_q.last       <= 1'b1;
						count_q          <= count_q + CW'(1);
						state_q          <= ST_IDLE;
					end
				end
				ST_REL_RD: begin
					state_q <= ST_REL_CMP;
				end
				ST_REL_CMP: begin
					// Hold one due entry back until the next head shows whether it is last
					if (rel_due) begin
						if (pend_valid_q) begin
							rsp_valid_q      <= 1'b1;
							rsp_q.kind       <= KIND_RELEASED;
							rsp_q.out_handle <= pend_q.handle;
							rsp_q.out_dest   <= pend_q.dest;
							rsp_q.last       <= 1'b0;
						end
						pend_q       <= rdata_q;
						pend_valid_q <= 1'b1;
						head_q       <= wrap_add(head_q, AW'(1));
						count_q      <= count_q - CW'(1);
						n_q          <= n_q + REL_W'(1);
						state_q      <= ST_REL_RD;
					end else begin
						if (pend_valid_q) begin
							rsp_valid_q      <= 1'b1;
							rsp_q.kind       <= KIND_RELEASED;
							rsp_q.out_handle <= pend_q.handle;
							rsp_q.out_dest   <= pend_q.dest;
							rsp_q.last       <= 1'b1;
						end
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
